FILE: src/rotary_encoder_page_selector_defines.svh
// ----------------------------------------------------------------------------
// Rotary encoder page selector: assertion macros
// Concurrent check macros used by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_PAGE_SELECTOR_DEFINES_SVH
`define ROTARY_ENCODER_PAGE_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check that holds at every clock edge outside reset
`define REP_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check that a condition in one cycle implies another in the next
`define REP_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`else
`define REP_ASSERT(label, expr, msg)
`define REP_ASSERT_NEXT(label, cond, expr, msg)
`endif

`endif

FILE: src/rep_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder page selector package
// Item types, quadrature transition table and page wrap helpers.
// ----------------------------------------------------------------------------
package rep_pkg;

  // Default number of pages
  localparam int PAGE_COUNT_DEF = 4;

  // Button lockout after reset, in ms
  localparam logic [9:0] LOCKOUT_RST = 10'd180;

  // Accumulator threshold for one detent
  localparam logic signed [3:0] STEP_LIMIT = 4'sd4;

  // Poll item
  typedef struct packed {
    logic        phase_a;
    logic        phase_b;
    logic        back_button;
    logic        confirm_button;
    logic [31:0] time_ms;
  } rep_in_t;

  // Result item
  typedef struct packed {
    logic [7:0]         page_index;
    logic signed [31:0] position;
    logic [15:0]        back_count;
    logic [15:0]        confirm_count;
    logic               level_a;
    logic               level_b;
    logic               level_back;
    logic               level_confirm;
  } rep_out_t;

  // Detent step from the quadrature decoder
  typedef struct packed {
    logic up;
    logic down;
  } rep_step_t;

  // Button decision for one item
  typedef struct packed {
    logic sample;   // outside lockout, levels are taken
    logic back;     // accepted back press
    logic confirm;  // accepted confirm press
  } rep_press_t;

  // x4 transition table, index {prev_phase, phase}
  function automatic logic signed [3:0] step_delta(input logic [3:0] idx);
    logic signed [3:0] d;
    unique case (idx)
      4'h1, 4'h7, 4'h8, 4'hE: d = -4'sd1;
      4'h2, 4'h4, 4'hB, 4'hD: d = 4'sd1;
      default:                d = 4'sd0;
    endcase
    return d;
  endfunction

  // Step page up, wrapping to 0
  function automatic logic [7:0] page_up(input logic [7:0] page, input logic [8:0] count);
    logic [8:0] nxt;
    nxt = {1'b0, page} + 9'd1;
    return (nxt >= count) ? 8'd0 : nxt[7:0];
  endfunction

  // Step page down, wrapping to count-1; a page above count goes to 0
  function automatic logic [7:0] page_down(input logic [7:0] page, input logic [8:0] count);
    logic [8:0] dec;
    logic [8:0] last;
    dec  = {1'b0, page} - 9'd1;
    last = count - 9'd1;
    if (page == 8'd0) begin
      return last[7:0];
    end else if (dec >= count) begin
      return 8'd0;
    end
    return dec[7:0];
  endfunction

endpackage

FILE: src/rep_quad_step.sv
// ----------------------------------------------------------------------------
// Quadrature step decoder
// Accumulates x4 transitions and flags a detent step at +4 or -4.
// ----------------------------------------------------------------------------
module rep_quad_step (
  input  logic [1:0]        phase,
  input  logic [1:0]        prev_phase,
  input  logic              phase_seen,
  input  logic signed [3:0] accum,
  output logic [1:0]        prev_phase_next,
  output logic signed [3:0] accum_next,
  output rep_pkg::rep_step_t step
);

  logic signed [3:0] sum;

  // Table lookup and add
  assign sum = accum + rep_pkg::step_delta({prev_phase, phase});

  // Phase tracking and detent detection
  always_comb begin
    prev_phase_next = prev_phase;
    accum_next      = accum;
    step            = '0;
    if (!phase_seen) begin
      prev_phase_next = phase;   // first sample only latches
    end else if (phase != prev_phase) begin
      prev_phase_next = phase;
      if (sum >= rep_pkg::STEP_LIMIT) begin
        step.up    = 1'b1;
        accum_next = '0;
      end else if (sum <= -rep_pkg::STEP_LIMIT) begin
        step.down  = 1'b1;
        accum_next = '0;
      end else begin
        accum_next = sum;
      end
    end
  end

endmodule

FILE: src/rep_button_gate.sv
// ----------------------------------------------------------------------------
// Button lockout gate
// Samples the buttons once the lockout has expired; back wins over confirm.
// ----------------------------------------------------------------------------
module rep_button_gate (
  input  logic [31:0]        time_ms,
  input  logic [31:0]        last_press_time,
  input  logic [9:0]         lockout_ms,
  input  logic               back_button,
  input  logic               confirm_button,
  output rep_pkg::rep_press_t press
);

  logic [31:0] elapsed;

  // Wrapping time difference
  assign elapsed = time_ms - last_press_time;

  // Lockout test and press priority (buttons active low)
  always_comb begin
    press.sample  = (elapsed >= {22'd0, lockout_ms});
    press.back    = press.sample && !back_button;
    press.confirm = press.sample && back_button && !confirm_button;
  end

endmodule

FILE: src/rotary_encoder_page_selector.sv
// ----------------------------------------------------------------------------
// Rotary encoder page selector
// Quadrature decoding, button lockout and page selection, one poll per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one poll item: encoder
//   A/B levels, active-low back and confirm buttons and a ms timestamp.
//   Output channel (out_valid/out_stall/out_data) gives one result per item:
//   page, signed position, press counters and the sampled levels.
//   Config: cfg_wr_en/cfg_wr_data write the button lockout time in ms; write
//   it only while no item is in flight.
//   A result passes an input register, then the decode/page logic into the
//   result register. Throughput is one
//   item per cycle, set by the state update in the result stage.
//   When the receiver stalls, the result register holds and the input
//   register takes one more item before in_stall rises.
//   Synchronous reset clears both stages and all state: page 0, position 0,
//   counters 0, levels all ones, lockout 180 ms, phase not yet seen. The
//   lockout also applies from time 0 after reset.
// ----------------------------------------------------------------------------
`include "rotary_encoder_page_selector_defines.svh"

module rotary_encoder_page_selector #(
  parameter int PAGE_COUNT = rep_pkg::PAGE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rep_pkg::rep_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rep_pkg::rep_out_t out_data,
  input  logic             cfg_wr_en,
  input  logic [9:0]       cfg_wr_data
);

  localparam logic [8:0] PageCnt = 9'(PAGE_COUNT);

  // Input stage
  logic             stage_valid;
  rep_pkg::rep_in_t stage_data;
  logic             advance;
  logic             fire;

  // Block state
  logic [9:0]         lockout_ms;
  logic [1:0]         prev_phase;
  logic               phase_seen;
  logic signed [3:0]  step_accum;
  logic [31:0]        last_press_time;
  logic [7:0]         page_reg;
  logic signed [31:0] position_reg;
  logic [15:0]        back_counter;
  logic [15:0]        confirm_counter;
  logic [1:0]         level_btn;

  // Next values
  logic [1:0]         prev_phase_next;
  logic signed [3:0]  step_accum_next;
  logic [7:0]         page_mid;
  logic [7:0]         page_reg_next;
  logic signed [31:0] position_reg_next;
  logic [15:0]        back_counter_next;
  logic [15:0]        confirm_counter_next;
  logic [31:0]        last_press_time_next;
  logic [1:0]         level_btn_next;

  rep_pkg::rep_step_t  step;
  rep_pkg::rep_press_t press;

  // Handshake: result register frees when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = stage_valid && !advance;
  assign fire     = stage_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      stage_data <= in_data;
    end
  end

  // Encoder decode
  rep_quad_step u_quad (
    .phase           ({stage_data.phase_a, stage_data.phase_b}),
    .prev_phase      (prev_phase),
    .phase_seen      (phase_seen),
    .accum           (step_accum),
    .prev_phase_next (prev_phase_next),
    .accum_next      (step_accum_next),
    .step            (step)
  );

  // Button lockout
  rep_button_gate u_btn (
    .time_ms         (stage_data.time_ms),
    .last_press_time (last_press_time),
    .lockout_ms      (lockout_ms),
    .back_button     (stage_data.back_button),
    .confirm_button  (stage_data.confirm_button),
    .press           (press)
  );

  // Page and counters: encoder step first, then button step
  always_comb begin
    page_mid             = page_reg;
    position_reg_next    = position_reg;
    back_counter_next    = back_counter;
    confirm_counter_next = confirm_counter;
    last_press_time_next = last_press_time;
    level_btn_next       = level_btn;
    if (step.up) begin
      page_mid          = rep_pkg::page_up(page_reg, PageCnt);
      position_reg_next = position_reg + 32'sd1;
    end else if (step.down) begin
      page_mid          = rep_pkg::page_down(page_reg, PageCnt);
      position_reg_next = position_reg - 32'sd1;
    end
    page_reg_next = page_mid;
    if (press.sample) begin
      level_btn_next = {stage_data.back_button, stage_data.confirm_button};
    end
    if (press.back) begin
      page_reg_next        = rep_pkg::page_down(page_mid, PageCnt);
      back_counter_next    = back_counter + 16'd1;
      last_press_time_next = stage_data.time_ms;
    end else if (press.confirm) begin
      page_reg_next        = rep_pkg::page_up(page_mid, PageCnt);
      confirm_counter_next = confirm_counter + 16'd1;
      last_press_time_next = stage_data.time_ms;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms      <= rep_pkg::LOCKOUT_RST;
      prev_phase      <= 2'b00;
      phase_seen      <= 1'b0;
      step_accum      <= '0;
      last_press_time <= '0;
      page_reg        <= '0;
      position_reg    <= '0;
      back_counter    <= '0;
      confirm_counter <= '0;
      level_btn       <= 2'b11;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lockout_ms <= cfg_wr_data;
      end
      if (advance) begin
        out_valid <= stage_valid;
      end
      if (fire) begin
        prev_phase      <= prev_phase_next;
        phase_seen      <= 1'b1;
        step_accum      <= step_accum_next;
        last_press_time <= last_press_time_next;
        page_reg        <= page_reg_next;
        position_reg    <= position_reg_next;
        back_counter    <= back_counter_next;
        confirm_counter <= confirm_counter_next;
        level_btn       <= level_btn_next;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.page_index    <= page_reg_next;
      out_data.position      <= position_reg_next;
      out_data.back_count    <= back_counter_next;
      out_data.confirm_count <= confirm_counter_next;
      out_data.level_a       <= stage_data.phase_a;
      out_data.level_b       <= stage_data.phase_b;
      out_data.level_back    <= level_btn_next[1];
      out_data.level_confirm <= level_btn_next[0];
    end
  end

  // Checks
  `REP_ASSERT(a_page_range, {1'b0, page_reg} < PageCnt, "page register out of range")
  `REP_ASSERT(a_accum_range, (step_accum < rep_pkg::STEP_LIMIT) && (step_accum > -rep_pkg::STEP_LIMIT), "step accumulator not cleared at a detent")
  `REP_ASSERT(a_one_press, !fire || !(press.back && press.confirm), "both buttons counted in one item")
  `REP_ASSERT_NEXT(a_fire_result, fire, out_valid, "processed item gave no result")
  `REP_ASSERT_NEXT(a_stage_hold, stage_valid && !advance, stage_valid, "input stage lost an item")

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Rotary encoder page selector testbench
// Feeds poll items (quadrature levels, active-low buttons, ms timestamp)
// through the valid/stall channels and checks every result against an
// in-bench model of the decoder, the button lockout and the page wrap.
// Directed cases come first, then random turning with noise, one long
// receiver hold-off and a final stretch without idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES  = rep_pkg::PAGE_COUNT_DEF;
  localparam int DETENT = 4;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  rep_pkg::rep_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rep_pkg::rep_out_t out_data;
  logic              cfg_wr_en = 1'b0;
  logic [9:0]        cfg_wr_data = '0;

  rotary_encoder_page_selector uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Model state of the selector
  logic [1:0]  trk_prev;
  logic        trk_seen;
  int          trk_accum;
  logic [31:0] trk_last_press;
  logic [7:0]  trk_page;
  logic [31:0] trk_pos;
  logic [15:0] trk_backs;
  logic [15:0] trk_confirms;
  logic [3:0]  trk_levels;   // a, b, back, confirm
  logic [31:0] trk_lockout;

  // Results still to come out of the block, oldest first
  rep_pkg::rep_out_t page_forecast[$];

  // Stimulus state
  logic [1:0]  knob;
  logic [31:0] clock_ms;
  logic        spin_cw = 1'b1;
  bit          sender_gaps = 1'b1;
  bit          receiver_gaps = 1'b1;
  int          hold_left = 0;
  int          stall_left = 0;
  int          items_sent = 0;
  int          fault_count = 0;
  rep_pkg::rep_out_t due;

  task automatic reset_tracker();
    trk_prev       = 2'b00;
    trk_seen       = 1'b0;
    trk_accum      = 0;
    trk_last_press = '0;
    trk_page       = '0;
    trk_pos        = '0;
    trk_backs      = '0;
    trk_confirms   = '0;
    trk_levels     = 4'hF;
    trk_lockout    = 32'(rep_pkg::LOCKOUT_RST);
  endtask

  // x4 decode: +1 per quarter turn clockwise, -1 counterclockwise
  function automatic int quad_delta(input logic [3:0] idx);
    case (idx)
      4'b0010, 4'b0100, 4'b1011, 4'b1101: return 1;
      4'b0001, 4'b0111, 4'b1000, 4'b1110: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] page_inc(input logic [7:0] p);
    int nxt;
    nxt = int'(p) + 1;
    return (nxt >= PAGES) ? 8'd0 : 8'(nxt);
  endfunction

  function automatic logic [7:0] page_dec(input logic [7:0] p);
    if (p == 8'd0) return 8'(PAGES - 1);
    if (int'(p) - 1 >= PAGES) return 8'd0;
    return p - 8'd1;
  endfunction

  // Advance the model by one poll and give the result it should produce
  function automatic rep_pkg::rep_out_t track_selector(input rep_pkg::rep_in_t poll);
    rep_pkg::rep_out_t r;
    logic [1:0]        ph;
    ph = {poll.phase_a, poll.phase_b};
    trk_levels[3:2] = ph;
    if (!trk_seen) begin
      trk_prev = ph;
      trk_seen = 1'b1;
    end else if (ph != trk_prev) begin
      trk_accum += quad_delta({trk_prev, ph});
      trk_prev = ph;
      if (trk_accum >= DETENT) begin
        trk_pos   = trk_pos + 32'd1;
        trk_page  = page_inc(trk_page);
        trk_accum = 0;
      end else if (trk_accum <= -DETENT) begin
        trk_pos   = trk_pos - 32'd1;
        trk_page  = page_dec(trk_page);
        trk_accum = 0;
      end
    end
    // buttons only outside the lockout window, modulo 2^32
    if (32'(poll.time_ms - trk_last_press) >= trk_lockout) begin
      trk_levels[1:0] = {poll.back_button, poll.confirm_button};
      if (!poll.back_button) begin
        trk_backs      = trk_backs + 16'd1;
        trk_page       = page_dec(trk_page);
        trk_last_press = poll.time_ms;
      end else if (!poll.confirm_button) begin
        trk_confirms   = trk_confirms + 16'd1;
        trk_page       = page_inc(trk_page);
        trk_last_press = poll.time_ms;
      end
    end
    r.page_index    = trk_page;
    r.position      = trk_pos;
    r.back_count    = trk_backs;
    r.confirm_count = trk_confirms;
    r.level_a       = trk_levels[3];
    r.level_b       = trk_levels[2];
    r.level_back    = trk_levels[1];
    r.level_confirm = trk_levels[0];
    return r;
  endfunction

  // Next gray-code phase, A as bit 1
  function automatic logic [1:0] quarter_turn(input logic [1:0] ph, input logic cw);
    case ({cw, ph})
      3'b100:  return 2'b10;
      3'b110:  return 2'b11;
      3'b111:  return 2'b01;
      3'b101:  return 2'b00;
      3'b000:  return 2'b01;
      3'b001:  return 2'b11;
      3'b011:  return 2'b10;
      default: return 2'b00;
    endcase
  endfunction

  // Offer one poll item and wait until it is taken
  task automatic send_poll(input logic [1:0] ph, input logic back_n, input logic confirm_n);
    rep_pkg::rep_in_t item;
    item.phase_a        = ph[1];
    item.phase_b        = ph[0];
    item.back_button    = back_n;
    item.confirm_button = confirm_n;
    item.time_ms        = clock_ms;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    page_forecast.push_back(track_selector(item));
    items_sent++;
  endtask

  // Drop valid and let every pending result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (page_forecast.size() != 0) @(posedge clk);
  endtask

  task automatic write_lockout(input logic [9:0] ms);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ms;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    trk_lockout = 32'(ms);
  endtask

  // Mostly steady turning, some reversals, jumps and held phases
  task automatic random_poll();
    int   pick;
    logic back_n;
    logic confirm_n;
    pick = $urandom_range(0, 99);
    if (pick < 8) spin_cw = ~spin_cw;
    if (pick < 75) knob = quarter_turn(knob, spin_cw);
    else if (pick < 88) knob = 2'($urandom);
    back_n    = ($urandom_range(0, 9) != 0);
    confirm_n = ($urandom_range(0, 6) != 0);
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + 32'($urandom_range(0, 160));
    send_poll(knob, back_n, confirm_n);
  endtask

  // Receiver: long hold-off on request, else random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result taken with the oldest forecast
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (page_forecast.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("ERROR: result with nothing pending: page %0d pos %0d",
                     out_data.page_index, out_data.position);
        end else begin
          due = page_forecast.pop_front();
          if (out_data.page_index !== due.page_index || out_data.position !== due.position ||
              out_data.back_count !== due.back_count ||
              out_data.confirm_count !== due.confirm_count ||
              out_data.level_a !== due.level_a || out_data.level_b !== due.level_b ||
              out_data.level_back !== due.level_back ||
              out_data.level_confirm !== due.level_confirm) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("ERROR: exp page %0d pos %0d back %0d conf %0d lv %b%b%b%b",
                       due.page_index, due.position, due.back_count, due.confirm_count,
                       due.level_a, due.level_b, due.level_back, due.level_confirm);
              $display("       got page %0d pos %0d back %0d conf %0d lv %b%b%b%b",
                       out_data.page_index, out_data.position, out_data.back_count,
                       out_data.confirm_count, out_data.level_a, out_data.level_b,
                       out_data.level_back, out_data.level_confirm);
            end
          end
        end
      end
    end
  end

  // First sample, lockout right after reset, both buttons at once
  task automatic test_reset_lockout();
    knob     = 2'b11;
    clock_ms = 32'd0;
    send_poll(knob, 1'b1, 1'b1);
    clock_ms = 32'd5;
    send_poll(knob, 1'b0, 1'b1);
    clock_ms = 32'd179;
    send_poll(knob, 1'b1, 1'b0);
    clock_ms = 32'd180;
    send_poll(knob, 1'b0, 1'b0);
  endtask

  // Detents both ways, held phase, illegal jump, partial turn and back
  task automatic test_quadrature();
    clock_ms = 32'd300;
    repeat (4) begin
      knob = quarter_turn(knob, 1'b1);
      send_poll(knob, 1'b1, 1'b1);
    end
    send_poll(knob, 1'b1, 1'b1);
    repeat (4) begin
      knob = quarter_turn(knob, 1'b0);
      send_poll(knob, 1'b1, 1'b1);
    end
    knob = ~knob;
    send_poll(knob, 1'b1, 1'b1);
    repeat (2) begin
      knob = quarter_turn(knob, 1'b1);
      send_poll(knob, 1'b1, 1'b1);
    end
    repeat (2) begin
      knob = quarter_turn(knob, 1'b0);
      send_poll(knob, 1'b1, 1'b1);
    end
  endtask

  // Presses, press inside lockout, detent with press, timestamp wrap
  task automatic test_buttons();
    clock_ms = 32'd1000;
    send_poll(knob, 1'b1, 1'b0);
    clock_ms = clock_ms + 32'd10;
    send_poll(knob, 1'b0, 1'b1);
    repeat (3) begin
      knob = quarter_turn(knob, 1'b1);
      send_poll(knob, 1'b1, 1'b1);
    end
    clock_ms = clock_ms + 32'd500;
    knob = quarter_turn(knob, 1'b1);
    send_poll(knob, 1'b1, 1'b0);
    clock_ms = 32'hFFFF_FFF0;
    send_poll(knob, 1'b0, 1'b1);
    clock_ms = 32'h0000_0020;
    send_poll(knob, 1'b0, 1'b1);
    clock_ms = 32'h0000_00C0;
    send_poll(knob, 1'b0, 1'b1);
  endtask

  // Shortest and longest lockout, then back to the reset value
  task automatic test_lockout_extremes();
    write_lockout(10'd0);
    send_poll(knob, 1'b0, 1'b1);
    send_poll(knob, 1'b1, 1'b0);
    send_poll(knob, 1'b0, 1'b0);
    write_lockout(10'h3FF);
    clock_ms = clock_ms + 32'd1022;
    send_poll(knob, 1'b1, 1'b0);
    clock_ms = clock_ms + 32'd1;
    send_poll(knob, 1'b1, 1'b0);
    write_lockout(rep_pkg::LOCKOUT_RST);
  endtask

  // Random turning under several lockout settings
  task automatic test_random_turning();
    for (int round = 0; round < 4; round++) begin
      case (round)
        0:       write_lockout(10'($urandom_range(0, 1023)));
        1:       write_lockout(10'h3FF);
        2:       write_lockout(10'd1);
        default: write_lockout(10'($urandom));
      endcase
      repeat (80) random_poll();
    end
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    hold_left     = 60;
    repeat (40) random_poll();
    wait_idle();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_steady_stream();
    write_lockout(10'($urandom_range(0, 300)));
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    repeat (60) random_poll();
  endtask

  initial begin
    reset_tracker();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_lockout();
    test_quadrature();
    test_buttons();
    test_lockout_extremes();
    test_random_turning();
    test_backpressure();
    test_steady_stream();
    wait_idle();
    repeat (4) @(posedge clk);
    $display("Ran %0d polls: detents both ways, illegal jumps, lockout 0/1/1023/random, ms wrap,",
             items_sent);
    $display("receiver hold-off; %0d back and %0d confirm presses, final page %0d position %0d",
             trk_backs, trk_confirms, trk_page, $signed(trk_pos));
    if (fault_count == 0) begin
      $display("rotary_encoder_page_selector verification clean");
    end else begin
      $display("rotary_encoder_page_selector verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d results pending", page_forecast.size());
    $display("rotary_encoder_page_selector verification failed");
    $finish;
  end

endmodule
